FILE: rtl/core/gaps_pkg.sv
// Shared types, constants and helper functions of the grid path search block.
package gaps_pkg;

  // Grid geometry and field widths
  localparam int COORD_W = 6;
  localparam int GRID_W  = 64;
  localparam int GRID_H  = 64;
  localparam int IDX_W   = 2 * COORD_W;
  localparam int NCELLS  = GRID_W * GRID_H;
  localparam int LEN_W   = IDX_W + 1;
  localparam int OCC_W   = 8;
  localparam int THR_W   = 7;
  localparam int OP_W    = 2;

  // Cost arithmetic
  localparam int COST_W    = 24;
  localparam int COST_FRAC = 10;
  localparam logic [COST_W-1:0] COST_MAX      = {COST_W{1'b1}};
  localparam logic [COST_W-1:0] STRAIGHT_COST = COST_W'(1) << COST_FRAC;
  // round(sqrt(2) * 2^10)
  localparam logic [COST_W-1:0] DIAG_COST     = COST_W'(1448);

  // Heuristic square root sizing
  localparam int SQ_W  = 2 * COORD_W + 1;
  localparam int RAD_W = SQ_W + 2 * COST_FRAC;
  localparam int NSTEP = (RAD_W + 1) / 2;
  localparam int H_W   = NSTEP;

  // Open list
  localparam int HEAP_AW = IDX_W + 1;
  localparam int KEY_W   = COST_W + IDX_W;

  // Register reset and special occupancy code
  localparam logic [THR_W-1:0]        THR_RESET   = THR_W'(50);
  localparam logic signed [OCC_W-1:0] OCC_UNKNOWN = -8'sd1;

  // Operation codes and result kinds
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_STEP   = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [COORD_W-1:0]      cell_x;
    logic [COORD_W-1:0]      cell_y;
    logic signed [OCC_W-1:0] occupancy;
    logic [COORD_W-1:0]      start_x;
    logic [COORD_W-1:0]      start_y;
    logic [COORD_W-1:0]      goal_x;
    logic [COORD_W-1:0]      goal_y;
    logic [IDX_W-1:0]        path_index;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic               found;
    logic [LEN_W-1:0]   path_length;
    logic [COST_W-1:0]  path_cost;
    logic [COORD_W-1:0] step_x;
    logic [COORD_W-1:0] step_y;
    logic               step_valid;
  } res_t;

  typedef struct packed {
    logic              is_open;
    logic              is_closed;
    logic [2:0]        dir;
    logic [COST_W-1:0] g;
  } node_t;

  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } heap_cmd_t;

  typedef struct packed {
    logic busy;
    logic empty;
  } heap_sts_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_PREP, S_RD_S, S_RD_G, S_EP, S_NB, S_NBCHK, S_HWAIT,
    S_PUSHW, S_POP, S_POPW, S_CUR, S_WALK, S_WALKD, S_PRD, S_REPORT
  } core_state_t;

  typedef enum logic [2:0] {
    H_IDLE, H_UP, H_FIN, H_POP1, H_DN
  } heap_state_t;

  typedef enum logic [1:0] {
    Q_IDLE, Q_SQ, Q_RUN, Q_DONE
  } heur_state_t;

  // Column step of each direction: E, W, S, N, SE, SW, NE, NW
  function automatic logic [COORD_W:0] dir_dx(input logic [2:0] d);
    logic [COORD_W:0] v;
    unique case (d)
      3'd0, 3'd4, 3'd6: v = (COORD_W+1)'(1);
      3'd1, 3'd5, 3'd7: v = {(COORD_W+1){1'b1}};
      default:          v = '0;
    endcase
    return v;
  endfunction

  // Row step of each direction
  function automatic logic [COORD_W:0] dir_dy(input logic [2:0] d);
    logic [COORD_W:0] v;
    unique case (d)
      3'd2, 3'd4, 3'd5: v = (COORD_W+1)'(1);
      3'd3, 3'd6, 3'd7: v = {(COORD_W+1){1'b1}};
      default:          v = '0;
    endcase
    return v;
  endfunction

  // Saturating cost add
  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

endpackage

FILE: rtl/core/gaps_heur.sv
// Heuristic unit: Euclidean distance in fixed point, one root bit per cycle.
module gaps_heur (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gaps_pkg::COORD_W-1:0]  x,
  input  logic [gaps_pkg::COORD_W-1:0]  y,
  input  logic [gaps_pkg::COORD_W-1:0]  gx,
  input  logic [gaps_pkg::COORD_W-1:0]  gy,
  output logic                          done,
  output logic [gaps_pkg::H_W-1:0]      h
);

  localparam int AW    = gaps_pkg::RAD_W + 1;
  localparam int CNT_W = $clog2(gaps_pkg::NSTEP + 1);
  localparam logic [AW-1:0] BIT0 = AW'(1) << (2 * (gaps_pkg::NSTEP - 1));

  gaps_pkg::heur_state_t state_r, state_nxt;
  logic [gaps_pkg::COORD_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [AW-1:0] v_r, v_nxt, r_r, r_nxt, bit_r, bit_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2*gaps_pkg::COORD_W-1:0] sq_x, sq_y;
  logic [gaps_pkg::SQ_W-1:0] sq_sum;
  logic [AW-1:0] trial;

  assign sq_x   = dx_r * dx_r;
  assign sq_y   = dy_r * dy_r;
  assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
  assign trial  = r_r + bit_r;
  assign h      = r_r[gaps_pkg::H_W-1:0];

  // Sequencer: abs diff, square and sum, then the root recurrence
  always_comb begin
    state_nxt = state_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    v_nxt     = v_r;
    r_nxt     = r_r;
    bit_nxt   = bit_r;
    cnt_nxt   = cnt_r;
    done      = 1'b0;
    unique case (state_r)
      gaps_pkg::Q_IDLE: begin
        if (start) begin
          dx_nxt    = (x > gx) ? x - gx : gx - x;
          dy_nxt    = (y > gy) ? y - gy : gy - y;
          state_nxt = gaps_pkg::Q_SQ;
        end
      end
      gaps_pkg::Q_SQ: begin
        v_nxt     = {1'b0, sq_sum, (2*gaps_pkg::COST_FRAC)'(0)};
        r_nxt     = '0;
        bit_nxt   = BIT0;
        cnt_nxt   = '0;
        state_nxt = gaps_pkg::Q_RUN;
      end
      gaps_pkg::Q_RUN: begin
        if (v_r >= trial) begin
          v_nxt = v_r - trial;
          r_nxt = (r_r >> 1) + bit_r;
        end else begin
          r_nxt = r_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(gaps_pkg::NSTEP - 1)) state_nxt = gaps_pkg::Q_DONE;
      end
      gaps_pkg::Q_DONE: begin
        done      = 1'b1;
        state_nxt = gaps_pkg::Q_IDLE;
      end
      default: state_nxt = gaps_pkg::Q_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gaps_pkg::Q_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    v_r   <= v_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

FILE: rtl/core/gaps_heap.sv
// Open list: binary min-heap of {f, cell index} keys in a two-read memory.
module gaps_heap (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gaps_pkg::heap_cmd_t         cmd,
  input  logic [gaps_pkg::KEY_W-1:0]  push_key,
  output gaps_pkg::heap_sts_t         sts,
  output logic [gaps_pkg::KEY_W-1:0]  top_key
);

  localparam int AW = gaps_pkg::HEAP_AW;
  localparam int KW = gaps_pkg::KEY_W;
  localparam logic [AW-1:0] FULL = {AW{1'b1}};

  logic [KW-1:0] mem [2**AW];
  logic [KW-1:0] rd_a, rd_b;
  logic [AW-1:0] ra_a, ra_b, wa;
  logic [KW-1:0] wd;
  logic          we;

  gaps_pkg::heap_state_t state_r, state_nxt;
  logic [AW-1:0] size_r, size_nxt, hole_r, hole_nxt;
  logic [KW-1:0] key_r, key_nxt, top_r, top_nxt;

  logic [AW:0]   c1, c2, m;
  logic          c1_ok, c2_ok;
  logic [KW-1:0] mk;
  logic [AW-1:0] parent;

  assign sts.busy  = (state_r != gaps_pkg::H_IDLE);
  assign sts.empty = (size_r == '0);
  assign top_key   = top_r;

  // Child selection for sift-down
  assign c1     = {hole_r, 1'b0};
  assign c2     = {hole_r, 1'b1};
  assign c1_ok  = c1 <= {1'b0, size_r};
  assign c2_ok  = c2 <= {1'b0, size_r};
  assign m      = (c2_ok && rd_b < rd_a) ? c2 : c1;
  assign mk     = (c2_ok && rd_b < rd_a) ? rd_b : rd_a;
  assign parent = hole_r >> 1;

  // Heap sequencer
  always_comb begin
    state_nxt = state_r;
    size_nxt  = size_r;
    hole_nxt  = hole_r;
    key_nxt   = key_r;
    top_nxt   = top_r;
    we        = 1'b0;
    wa        = hole_r;
    wd        = key_r;
    ra_a      = hole_r >> 1;
    ra_b      = hole_r;
    unique case (state_r)
      gaps_pkg::H_IDLE: begin
        if (cmd.clr) begin
          size_nxt = '0;
        end else if (cmd.push && size_r != FULL) begin
          size_nxt = size_r + AW'(1);
          hole_nxt = size_r + AW'(1);
          key_nxt  = push_key;
          ra_a     = hole_nxt >> 1;
          if (size_r == '0) begin
            we = 1'b1;
            wa = AW'(1);
            wd = push_key;
          end else begin
            state_nxt = gaps_pkg::H_UP;
          end
        end else if (cmd.pop && size_r != '0) begin
          ra_a      = AW'(1);
          ra_b      = size_r;
          state_nxt = gaps_pkg::H_POP1;
        end
      end
      gaps_pkg::H_UP: begin
        we = 1'b1;
        if (key_r < rd_a) begin
          wd       = rd_a;
          hole_nxt = parent;
          ra_a     = parent >> 1;
          if (parent == AW'(1)) state_nxt = gaps_pkg::H_FIN;
        end else begin
          state_nxt = gaps_pkg::H_IDLE;
        end
      end
      gaps_pkg::H_FIN: begin
        we        = 1'b1;
        state_nxt = gaps_pkg::H_IDLE;
      end
      gaps_pkg::H_POP1: begin
        top_nxt  = rd_a;
        key_nxt  = rd_b;
        size_nxt = size_r - AW'(1);
        hole_nxt = AW'(1);
        ra_a     = AW'(2);
        ra_b     = AW'(3);
        state_nxt = (size_r == AW'(1)) ? gaps_pkg::H_IDLE : gaps_pkg::H_DN;
      end
      gaps_pkg::H_DN: begin
        we = 1'b1;
        if (c1_ok && mk < key_r) begin
          wd       = mk;
          hole_nxt = m[AW-1:0];
          ra_a     = {m[AW-2:0], 1'b0};
          ra_b     = {m[AW-2:0], 1'b1};
        end else begin
          state_nxt = gaps_pkg::H_IDLE;
        end
      end
      default: state_nxt = gaps_pkg::H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gaps_pkg::H_IDLE;
      size_r  <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
    end
    hole_r <= hole_nxt;
    key_r  <= key_nxt;
    top_r  <= top_nxt;
  end

  // Key memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

endmodule

FILE: rtl/core/gaps_core.sv
// Search core: cell stores, search sequencer, path walk and path read-back.
module gaps_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [gaps_pkg::THR_W-1:0]  threshold,
  input  logic                        req_valid,
  input  gaps_pkg::in_item_t          req,
  output logic                        idle,
  output logic                        res_valid,
  output gaps_pkg::res_t              res
);

  localparam int CW = gaps_pkg::COORD_W;
  localparam int IW = gaps_pkg::IDX_W;
  localparam int LW = gaps_pkg::LEN_W;
  localparam int GW = gaps_pkg::COST_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(gaps_pkg::NCELLS - 1);

  // Cell stores
  logic                free_mem [gaps_pkg::NCELLS];
  gaps_pkg::node_t     node_mem [gaps_pkg::NCELLS];
  logic [IW-1:0]       path_mem [gaps_pkg::NCELLS];

  logic          free_we, free_wd, free_rd;
  logic [IW-1:0] free_wa, free_ra;
  logic          node_we;
  logic [IW-1:0] node_wa, node_ra;
  gaps_pkg::node_t node_wd, node_rd;
  logic          path_we;
  logic [IW-1:0] path_wa, path_ra, path_wd, path_rd;

  // Sequencer registers
  gaps_pkg::core_state_t state_r, state_nxt;
  logic [IW-1:0] sweep_r, sweep_nxt;
  logic [CW-1:0] sx_r, sx_nxt, sy_r, sy_nxt, gx_r, gx_nxt, gy_r, gy_nxt;
  logic          sfree_r, sfree_nxt;
  logic [IW-1:0] cur_r, cur_nxt, nb_r, nb_nxt;
  logic [GW-1:0] gcur_r, gcur_nxt, tg_r, tg_nxt, cost_r, cost_nxt;
  logic [3:0]    d_r, d_nxt;
  logic [LW-1:0] len_r, len_nxt, cnt_r, cnt_nxt;
  logic          found_r, found_nxt, hit_r, hit_nxt;

  // Heap and heuristic hookup
  gaps_pkg::heap_cmd_t hcmd;
  gaps_pkg::heap_sts_t hsts;
  logic [gaps_pkg::KEY_W-1:0] top_key;
  logic                       h_start, h_done;
  logic [CW-1:0]              hx, hy;
  logic [gaps_pkg::H_W-1:0]   h;
  logic [GW-1:0]              f_val;

  logic [IW-1:0] s_idx, g_idx;
  logic [CW:0]   dx7, dy7, nx7, ny7, wdx, wdy;
  logic          in_grid;
  logic [GW-1:0] step_cost, tg_cand;
  logic          occ_free;

  gaps_heap u_heap (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (hcmd),
    .push_key ({f_val, nb_r}),
    .sts      (hsts),
    .top_key  (top_key)
  );

  gaps_heur u_heur (
    .clk   (clk),
    .rst_n (rst_n),
    .start (h_start),
    .x     (hx),
    .y     (hy),
    .gx    (gx_r),
    .gy    (gy_r),
    .done  (h_done),
    .h     (h)
  );

  assign s_idx = {sy_r, sx_r};
  assign g_idx = {gy_r, gx_r};
  assign f_val = gaps_pkg::sat_add(tg_r, GW'(h));

  // Neighbor of the expanded cell in direction d_r
  assign dx7     = gaps_pkg::dir_dx(d_r[2:0]);
  assign dy7     = gaps_pkg::dir_dy(d_r[2:0]);
  assign nx7     = {1'b0, cur_r[CW-1:0]} + dx7;
  assign ny7     = {1'b0, cur_r[IW-1:CW]} + dy7;
  assign in_grid = (nx7 < (CW+1)'(gaps_pkg::GRID_W)) && (ny7 < (CW+1)'(gaps_pkg::GRID_H));

  // Predecessor step for the path walk
  assign wdx = gaps_pkg::dir_dx(node_rd.dir);
  assign wdy = gaps_pkg::dir_dy(node_rd.dir);

  assign step_cost = d_r[2] ? gaps_pkg::DIAG_COST : gaps_pkg::STRAIGHT_COST;
  assign tg_cand   = gaps_pkg::sat_add(gcur_r, step_cost);

  // Cell value to free flag
  assign occ_free = (req.occupancy != gaps_pkg::OCC_UNKNOWN) &&
                    (req.occupancy < $signed({1'b0, threshold}));

  assign idle = (state_r == gaps_pkg::S_IDLE);

  // Search sequencer
  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    gx_nxt    = gx_r;
    gy_nxt    = gy_r;
    sfree_nxt = sfree_r;
    cur_nxt   = cur_r;
    nb_nxt    = nb_r;
    gcur_nxt  = gcur_r;
    tg_nxt    = tg_r;
    cost_nxt  = cost_r;
    d_nxt     = d_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    hit_nxt   = hit_r;
    free_we   = 1'b0;
    free_wa   = sweep_r;
    free_wd   = 1'b0;
    free_ra   = s_idx;
    node_we   = 1'b0;
    node_wa   = sweep_r;
    node_wd   = '0;
    node_ra   = cur_r;
    path_we   = 1'b0;
    path_wa   = cnt_r[IW-1:0] - IW'(1);
    path_wd   = cur_r;
    path_ra   = len_r[IW-1:0] - IW'(1) - req.path_index;
    hcmd      = '0;
    h_start   = 1'b0;
    hx        = nb_r[CW-1:0];
    hy        = nb_r[IW-1:CW];
    res_valid = 1'b0;
    res       = '0;
    unique case (state_r)
      gaps_pkg::S_INIT: begin
        free_we   = 1'b1;
        sweep_nxt = sweep_r + IW'(1);
        if (sweep_r == LAST_IDX) state_nxt = gaps_pkg::S_IDLE;
      end
      gaps_pkg::S_IDLE: begin
        if (req_valid) begin
          priority if (req.op == gaps_pkg::OP_LOAD) begin
            free_we = 1'b1;
            free_wa = {req.cell_y, req.cell_x};
            free_wd = occ_free;
          end else if (req.op == gaps_pkg::OP_SEARCH) begin
            sx_nxt    = req.start_x;
            sy_nxt    = req.start_y;
            gx_nxt    = req.goal_x;
            gy_nxt    = req.goal_y;
            len_nxt   = '0;
            cost_nxt  = '0;
            found_nxt = 1'b0;
            sweep_nxt = '0;
            hcmd.clr  = 1'b1;
            state_nxt = gaps_pkg::S_PREP;
          end else if (req.op == gaps_pkg::OP_READ) begin
            hit_nxt   = {1'b0, req.path_index} < len_r;
            state_nxt = gaps_pkg::S_PRD;
          end else begin
            state_nxt = gaps_pkg::S_IDLE;
          end
        end
      end
      gaps_pkg::S_PRD: begin
        res_valid      = 1'b1;
        res.kind       = gaps_pkg::KIND_STEP;
        res.step_valid = hit_r;
        if (hit_r) begin
          res.step_x = path_rd[CW-1:0];
          res.step_y = path_rd[IW-1:CW];
        end
        state_nxt = gaps_pkg::S_IDLE;
      end
      // Clear open and closed marks of every cell
      gaps_pkg::S_PREP: begin
        node_we   = 1'b1;
        sweep_nxt = sweep_r + IW'(1);
        if (sweep_r == LAST_IDX) state_nxt = gaps_pkg::S_RD_S;
      end
      gaps_pkg::S_RD_S: begin
        free_ra   = s_idx;
        state_nxt = gaps_pkg::S_RD_G;
      end
      gaps_pkg::S_RD_G: begin
        free_ra   = g_idx;
        sfree_nxt = free_rd;
        state_nxt = gaps_pkg::S_EP;
      end
      // Endpoints checked; report when either is blocked, else seed the open list with the start cell
      gaps_pkg::S_EP: begin
        if (!(sfree_r && free_rd)) begin
          state_nxt = gaps_pkg::S_REPORT;
        end else begin
          node_we         = 1'b1;
          node_wa         = s_idx;
          node_wd.is_open = 1'b1;
          tg_nxt          = '0;
          nb_nxt          = s_idx;
          d_nxt           = 4'd7;
          h_start         = 1'b1;
          hx              = sx_r;
          hy              = sy_r;
          state_nxt       = gaps_pkg::S_HWAIT;
        end
      end
      gaps_pkg::S_HWAIT: begin
        if (h_done) begin
          hcmd.push = 1'b1;
          state_nxt = gaps_pkg::S_PUSHW;
        end
      end
      gaps_pkg::S_PUSHW: begin
        if (!hsts.busy) begin
          d_nxt     = d_r + 4'd1;
          state_nxt = gaps_pkg::S_NB;
        end
      end
      gaps_pkg::S_NB: begin
        if (d_r[3]) begin
          state_nxt = gaps_pkg::S_POP;
        end else if (!in_grid) begin
          d_nxt = d_r + 4'd1;
        end else begin
          nb_nxt    = {ny7[CW-1:0], nx7[CW-1:0]};
          free_ra   = nb_nxt;
          node_ra   = nb_nxt;
          state_nxt = gaps_pkg::S_NBCHK;
        end
      end
      // Relax the neighbor when it is new or reached cheaper
      gaps_pkg::S_NBCHK: begin
        if (free_rd && !node_rd.is_closed &&
            (!node_rd.is_open || tg_cand < node_rd.g)) begin
          node_we         = 1'b1;
          node_wa         = nb_r;
          node_wd.is_open = 1'b1;
          node_wd.dir     = d_r[2:0];
          node_wd.g       = tg_cand;
          tg_nxt          = tg_cand;
          h_start         = 1'b1;
          state_nxt       = gaps_pkg::S_HWAIT;
        end else begin
          d_nxt     = d_r + 4'd1;
          state_nxt = gaps_pkg::S_NB;
        end
      end
      gaps_pkg::S_POP: begin
        if (hsts.empty) begin
          state_nxt = gaps_pkg::S_REPORT;
        end else begin
          hcmd.pop  = 1'b1;
          state_nxt = gaps_pkg::S_POPW;
        end
      end
      gaps_pkg::S_POPW: begin
        if (!hsts.busy) begin
          cur_nxt   = top_key[IW-1:0];
          node_ra   = cur_nxt;
          state_nxt = gaps_pkg::S_CUR;
        end
      end
      // Skip stale entries, close the cell, stop at the goal
      gaps_pkg::S_CUR: begin
        if (node_rd.is_closed) begin
          state_nxt = gaps_pkg::S_POP;
        end else begin
          node_we           = 1'b1;
          node_wa           = cur_r;
          node_wd           = node_rd;
          node_wd.is_open   = 1'b0;
          node_wd.is_closed = 1'b1;
          gcur_nxt          = node_rd.g;
          if (cur_r == g_idx) begin
            cost_nxt  = node_rd.g;
            cnt_nxt   = LW'(1);
            state_nxt = gaps_pkg::S_WALK;
          end else begin
            d_nxt     = 4'd0;
            state_nxt = gaps_pkg::S_NB;
          end
        end
      end
      // Path stored goal first; reads index it from the far end
      gaps_pkg::S_WALK: begin
        path_we = 1'b1;
        if (cur_r == s_idx) begin
          len_nxt   = cnt_r;
          found_nxt = 1'b1;
          state_nxt = gaps_pkg::S_REPORT;
        end else begin
          node_ra   = cur_r;
          state_nxt = gaps_pkg::S_WALKD;
        end
      end
      gaps_pkg::S_WALKD: begin
        cur_nxt   = {cur_r[IW-1:CW] - wdy[CW-1:0], cur_r[CW-1:0] - wdx[CW-1:0]};
        cnt_nxt   = cnt_r + LW'(1);
        state_nxt = gaps_pkg::S_WALK;
      end
      gaps_pkg::S_REPORT: begin
        res_valid       = 1'b1;
        res.kind        = gaps_pkg::KIND_REPORT;
        res.found       = found_r;
        res.path_length = len_r;
        res.path_cost   = cost_r;
        state_nxt       = gaps_pkg::S_IDLE;
      end
      default: state_nxt = gaps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gaps_pkg::S_INIT;
      sweep_r <= '0;
      len_r   <= '0;
      found_r <= 1'b0;
      cost_r  <= '0;
    end else begin
      state_r <= state_nxt;
      sweep_r <= sweep_nxt;
      len_r   <= len_nxt;
      found_r <= found_nxt;
      cost_r  <= cost_nxt;
    end
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    gx_r    <= gx_nxt;
    gy_r    <= gy_nxt;
    sfree_r <= sfree_nxt;
    cur_r   <= cur_nxt;
    nb_r    <= nb_nxt;
    gcur_r  <= gcur_nxt;
    tg_r    <= tg_nxt;
    d_r     <= d_nxt;
    cnt_r   <= cnt_nxt;
    hit_r   <= hit_nxt;
  end

  // Free map
  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd <= free_mem[free_ra];
  end

  // Per-cell search node: open, closed, came-from direction, g
  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    node_rd <= node_mem[node_ra];
  end

  // Path store
  always_ff @(posedge clk) begin
    if (path_we) path_mem[path_wa] <= path_wd;
    path_rd <= path_mem[path_ra];
  end

endmodule

FILE: rtl/core/grid_astar_path_search.sv
// Top level of the grid path search block: ports, threshold register, result register.
//
//  channel  | dir | transfer                         | tdata / tuser
//  ---------+-----+----------------------------------+---------------------------------
//  in_*     | in  | load cell, run search, read path | item fields / op
//  out_*    | out | search report or path entry      | result fields / kind
//  cfg_*    | in  | threshold write, no handshake    | cfg_wr_data = threshold
//
// After reset the free map is cleared, with in_tready low.
// A cell load writes the free map directly; a path read goes through the path store port.
// A search first clears the node store, then per expanded cell makes about
// 8 node-store reads plus, per relaxed neighbor, a square root and a heap push;
// the path walk then follows the came-from directions from the goal back to the start.
// The result register frees as soon as out_tready is high; loads pass a held result.
module grid_astar_path_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: cell_x[5:0] cell_y[11:6] occupancy[19:12] start_x[25:20] start_y[31:26]
  //        goal_x[37:32] goal_y[43:38] path_index[55:44]
  input  logic [55:0] in_tdata,
  // tuser: op[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: found[0] path_length[13:1] path_cost[37:14] step_x[43:38] step_y[49:44]
  //        step_valid[50] zero[55:51]
  output logic [55:0] out_tdata,
  // tuser: kind[0]
  output logic        out_tuser,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  logic [gaps_pkg::THR_W-1:0] thr_r;
  gaps_pkg::in_item_t item;
  gaps_pkg::res_t     res, res_r;
  logic               core_idle, res_valid, accept, out_valid_r;

  // Unpack input transfer
  assign item.op         = in_tuser;
  assign item.cell_x     = in_tdata[5:0];
  assign item.cell_y     = in_tdata[11:6];
  assign item.occupancy  = in_tdata[19:12];
  assign item.start_x    = in_tdata[25:20];
  assign item.start_y    = in_tdata[31:26];
  assign item.goal_x     = in_tdata[37:32];
  assign item.goal_y     = in_tdata[43:38];
  assign item.path_index = in_tdata[55:44];

  // Take an item when idle and the result slot is free or being drained, or the item is a cell load
  assign in_tready = core_idle &&
                     (!out_valid_r || out_tready || in_tuser == gaps_pkg::OP_LOAD);
  assign accept    = in_tvalid && in_tready;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= gaps_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  gaps_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (thr_r),
    .req_valid (accept),
    .req       (item),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {5'b0, res_r.step_valid, res_r.step_y, res_r.step_x,
                       res_r.path_cost, res_r.path_length, res_r.found};

`ifndef SYNTHESIS
  // A new result never lands on a held one
  assert property (@(posedge clk) disable iff (!rst_n)
    !(res_valid && out_valid_r && !out_tready))
    else $error("result register overwritten");

  // A path read answers in the following cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == gaps_pkg::OP_READ) |=> res_valid)
    else $error("path read result missing");

  // A cell load leaves the core idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == gaps_pkg::OP_LOAD) |=> core_idle)
    else $error("cell load left core busy");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench of the grid path search block: own A* model, scoreboard, stimulus.
module tb_top;
  import gaps_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int unsigned STEP_STRAIGHT = 1024;
  localparam int unsigned STEP_DIAG     = 1448;
  localparam int unsigned SAT_COST      = 24'hFFFFFF;

  // Scoreboard: grid planner model plus queue of pending results
  class path_scoreboard;
    bit [6:0]    thr;
    bit          free_cell [NCELLS];
    int unsigned g_cost [NCELLS];
    int unsigned f_cost [NCELLS];
    bit [2:0]    back_dir [NCELLS];
    bit          is_open [NCELLS];
    bit          is_closed [NCELLS];
    int unsigned path_cells [NCELLS];
    int unsigned path_len;
    int unsigned path_total;
    res_t        pending [$];
    int          errors;

    function new();
      thr = 7'd50;
      foreach (free_cell[i]) free_cell[i] = 0;
      path_len = 0;
      path_total = 0;
      errors = 0;
    endfunction

    function int step_x(int d);
      case (d)
        0, 4, 6: return 1;
        1, 5, 7: return -1;
        default: return 0;
      endcase
    endfunction

    function int step_y(int d);
      case (d)
        2, 4, 5: return 1;
        3, 6, 7: return -1;
        default: return 0;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function int unsigned add_sat(longint unsigned a, longint unsigned b);
      return (a + b > SAT_COST) ? SAT_COST : int'(a + b);
    endfunction

    // Euclidean distance to the goal in fixed point with 10 fraction bits
    function int unsigned dist_est(int x, int y, int gx, int gy);
      longint unsigned dx, dy, r;
      dx = (x > gx) ? x - gx : gx - x;
      dy = (y > gy) ? y - gy : gy - y;
      r = int_sqrt((dx * dx + dy * dy) << 20);
      return (r > SAT_COST) ? SAT_COST : int'(r);
    endfunction

    function bit astar(int sx, int sy, int gx, int gy);
      int s, gi, cur, k, best, cx, cy, nx, ny, nb, n;
      int unsigned tg;
      int frontier [$];
      foreach (is_open[i]) begin
        is_open[i] = 0;
        is_closed[i] = 0;
      end
      path_len = 0;
      path_total = 0;
      s = sy * GRID_W + sx;
      gi = gy * GRID_W + gx;
      if (!free_cell[s] || !free_cell[gi]) return 0;
      g_cost[s] = 0;
      f_cost[s] = dist_est(sx, sy, gx, gy);
      is_open[s] = 1;
      frontier.insert(frontier.size(), s);
      forever begin
        if (frontier.size() == 0) return 0;
        best = 0;
        for (k = 1; k < frontier.size(); k++) begin
          if (f_cost[frontier[k]] < f_cost[frontier[best]] ||
              (f_cost[frontier[k]] == f_cost[frontier[best]] &&
               frontier[k] < frontier[best]))
            best = k;
        end
        cur = frontier[best];
        frontier.delete(best);
        is_open[cur] = 0;
        is_closed[cur] = 1;
        if (cur == gi) break;
        cx = cur % GRID_W;
        cy = cur / GRID_W;
        for (int d = 0; d < 8; d++) begin
          nx = cx + step_x(d);
          ny = cy + step_y(d);
          if (nx < 0 || ny < 0 || nx >= GRID_W || ny >= GRID_H) continue;
          nb = ny * GRID_W + nx;
          if (!free_cell[nb] || is_closed[nb]) continue;
          tg = add_sat(g_cost[cur], d < 4 ? STEP_STRAIGHT : STEP_DIAG);
          if (!is_open[nb] || tg < g_cost[nb]) begin
            g_cost[nb] = tg;
            back_dir[nb] = 3'(d);
            f_cost[nb] = add_sat(tg, dist_est(nx, ny, gx, gy));
            if (!is_open[nb]) begin
              is_open[nb] = 1;
              frontier.insert(frontier.size(), nb);
            end
          end
        end
      end
      // walk back from the goal to count cells, then fill from the end
      n = 1;
      cur = gi;
      while (cur != s) begin
        cur = (cur / GRID_W - step_y(back_dir[cur])) * GRID_W +
              (cur % GRID_W - step_x(back_dir[cur]));
        n++;
      end
      path_len = n;
      path_total = g_cost[gi];
      cur = gi;
      for (k = n - 1; k >= 0; k--) begin
        path_cells[k] = cur;
        if (cur != s)
          cur = (cur / GRID_W - step_y(back_dir[cur])) * GRID_W +
                (cur % GRID_W - step_x(back_dir[cur]));
      end
      return 1;
    endfunction

    // Accepted input transfer: update model, queue its result
    function void note_input(in_item_t it);
      res_t r;
      r = '0;
      case (it.op)
        OP_LOAD: begin
          free_cell[it.cell_y * GRID_W + it.cell_x] =
            (it.occupancy != OCC_UNKNOWN) && (int'(it.occupancy) < int'(thr));
        end
        OP_SEARCH: begin
          r.kind = KIND_REPORT;
          r.found = astar(it.start_x, it.start_y, it.goal_x, it.goal_y);
          r.path_length = LEN_W'(path_len);
          r.path_cost = COST_W'(path_total);
          pending.insert(pending.size(), r);
        end
        OP_READ: begin
          r.kind = KIND_STEP;
          if (it.path_index < path_len) begin
            r.step_x = COORD_W'(path_cells[it.path_index] % GRID_W);
            r.step_y = COORD_W'(path_cells[it.path_index] / GRID_W);
            r.step_valid = 1;
          end
          pending.insert(pending.size(), r);
        end
        default: ;
      endcase
    endfunction

    // Accepted output transfer: compare with oldest expectation
    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.kind != e.kind)
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, got.kind);
      if (got.found != e.found)
        $display("%0t: found expected %0d actual %0d", $time, e.found, got.found);
      if (got.path_length != e.path_length)
        $display("%0t: path_length expected %0d actual %0d", $time, e.path_length,
                 got.path_length);
      if (got.path_cost != e.path_cost)
        $display("%0t: path_cost expected %0d actual %0d", $time, e.path_cost,
                 got.path_cost);
      if (got.step_x != e.step_x)
        $display("%0t: step_x expected %0d actual %0d", $time, e.step_x, got.step_x);
      if (got.step_y != e.step_y)
        $display("%0t: step_y expected %0d actual %0d", $time, e.step_y, got.step_y);
      if (got.step_valid != e.step_valid)
        $display("%0t: step_valid expected %0d actual %0d", $time, e.step_valid,
                 got.step_valid);
      if (got != e) errors++;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;

  path_scoreboard sb;
  int   send_idle_pct;
  int   stall_pct;
  int   hold_cycles;
  logic out_fire;
  res_t out_seen;

  grid_astar_path_search u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Sample the output handshake mid-cycle, check at the edge
  always @(negedge clk) begin
    out_fire <= out_tvalid && out_tready && rst_n;
    out_seen.kind        <= out_tuser;
    out_seen.found       <= out_tdata[0];
    out_seen.path_length <= out_tdata[13:1];
    out_seen.path_cost   <= out_tdata[37:14];
    out_seen.step_x      <= out_tdata[43:38];
    out_seen.step_y      <= out_tdata[49:44];
    out_seen.step_valid  <= out_tdata[50];
  end

  always @(posedge clk) begin
    if (out_fire === 1'b1) sb.check_result(out_seen);
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send(in_item_t it);
    bit ok;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {it.path_index, it.goal_y, it.goal_x, it.start_y, it.start_x,
                  it.occupancy, it.cell_y, it.cell_x};
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    sb.note_input(it);
  endtask

  task automatic load_cell(int x, int y, int occ);
    in_item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.cell_x = COORD_W'(x);
    it.cell_y = COORD_W'(y);
    it.occupancy = OCC_W'(occ);
    it.start_x = COORD_W'($urandom);
    it.goal_y = COORD_W'($urandom);
    send(it);
  endtask

  task automatic search(int sx, int sy, int gx, int gy);
    in_item_t it;
    it = '0;
    it.op = OP_SEARCH;
    it.start_x = COORD_W'(sx);
    it.start_y = COORD_W'(sy);
    it.goal_x = COORD_W'(gx);
    it.goal_y = COORD_W'(gy);
    it.cell_x = COORD_W'($urandom);
    send(it);
  endtask

  task automatic read_step(int idx);
    in_item_t it;
    it = '0;
    it.op = OP_READ;
    it.path_index = IDX_W'(idx);
    it.occupancy = OCC_W'($urandom);
    send(it);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_threshold(int v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= THR_W'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.thr = THR_W'(v);
  endtask

  function automatic int rand_occ();
    case ($urandom_range(9))
      6:       return -1;
      7:       return 100;
      8:       return $signed(8'($urandom));
      9:       return $urandom_range(100);
      default: return $urandom_range(40);
    endcase
  endfunction

  // Load a small patch of the map, search to goals inside it, read paths, then reload it as unknown or 100
  task automatic patch_round(int w, int h, int n_search, bit press);
    int x0, y0, idx;
    x0 = $urandom_range(GRID_W - w);
    y0 = $urandom_range(GRID_H - h);
    for (int y = y0; y < y0 + h; y++)
      for (int x = x0; x < x0 + w; x++)
        load_cell(x, y, rand_occ());
    for (int s = 0; s < n_search; s++) begin
      if ($urandom_range(9) == 0)
        search($urandom_range(63), $urandom_range(63), x0 + $urandom_range(w - 1),
               y0 + $urandom_range(h - 1));
      else
        search(x0 + $urandom_range(w - 1), y0 + $urandom_range(h - 1),
               x0 + $urandom_range(w - 1), y0 + $urandom_range(h - 1));
      if (press && s == 0) hold_cycles = 400;
      for (int r = 0; r < (press && s == 0 ? 30 : 4); r++) begin
        case ($urandom_range(4))
          0:       idx = $urandom_range(4095);
          1:       idx = sb.path_len + $urandom_range(2);
          default: idx = $urandom_range(sb.path_len);
        endcase
        read_step(idx);
      end
    end
    for (int y = y0; y < y0 + h; y++)
      for (int x = x0; x < x0 + w; x++)
        load_cell(x, y, $urandom_range(1) ? -1 : 100);
    read_step(0);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_LOAD;
    out_tready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    out_fire = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corners, diagonal past blocked corners, special values
    load_cell(0, 0, 0);
    load_cell(1, 1, 49);
    load_cell(63, 63, -128);
    load_cell(62, 62, -1);
    load_cell(63, 62, 50);
    search(0, 0, 0, 0);
    search(0, 0, 1, 1);
    read_step(0);
    read_step(1);
    read_step(2);
    read_step(4095);
    search(63, 63, 62, 62);
    search(62, 62, 63, 63);
    search(0, 0, 63, 63);
    read_step(0);
    begin
      in_item_t junk;
      junk = '1;
      junk.op = OP_NONE;
      send(junk);
    end
    load_cell(0, 0, 127);
    load_cell(1, 1, 100);
    load_cell(63, 63, 100);
    // straight corridor along the bottom row
    for (int x = 48; x < 64; x++) load_cell(x, 63, 1);
    search(48, 63, 63, 63);
    read_step(15);
    for (int x = 48; x < 64; x++) load_cell(x, 63, -1);

    // Random phases under different idle patterns and thresholds
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      for (int rnd = 0; rnd < 4; rnd++) begin
        case ((ph * 4 + rnd) % 5)
          0: write_threshold(0);
          1: write_threshold(100);
          2: write_threshold(127);
          3: write_threshold(50);
          default: write_threshold($urandom_range(127));
        endcase
        if (rnd == 3)
          patch_round(1, $urandom_range(8, 12), 3, ph == 0);
        else
          patch_round($urandom_range(3, 7), $urandom_range(3, 7), 3, ph == 0 && rnd == 0);
      end
    end

    drain_results();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #80000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
